### rtl/assert_macros.svh
// Assertion shorthands used by pixel_bucket_sort.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pbs_pkg.sv
package pbs_pkg;

  localparam int PIX_W = 32;
  localparam int CFG_W = 9;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd16;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAG,
    ST_CNT,
    ST_PFX,
    ST_SC_RD,
    ST_SC_POS,
    ST_SC_WR,
    ST_EMIT
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_TAG
  } alu_op_t;

endpackage

### rtl/pbs_ifs.sv
interface pbs_in_if #(
  parameter int KEY_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic [pbs_pkg::PIX_W-1:0]  pixel_value;
  logic [KEY_BITS-1:0]        sort_key;
  logic                       segment_end;

  modport source (output valid, pixel_value, sort_key, segment_end, input ready);
  modport sink   (input valid, pixel_value, sort_key, segment_end, output ready);
endinterface

interface pbs_out_if;
  logic                       valid;
  logic                       ready;
  logic [pbs_pkg::PIX_W-1:0]  sorted_pixel;
  logic                       final_pixel;

  modport source (output valid, sorted_pixel, final_pixel, input ready);
  modport sink   (input valid, sorted_pixel, final_pixel, output ready);
endinterface

### rtl/pbs_ram.sv
module pbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the last read word while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/pbs_alu.sv
module pbs_alu #(
  parameter int KEY_BITS    = 16,
  parameter int MAX_BUCKETS = 256,
  parameter int NW          = 9,
  parameter int RW          = 8
) (
  input  pbs_pkg::alu_op_t            op,
  input  logic [KEY_BITS-1:0]         key,
  input  logic [pbs_pkg::CFG_W-1:0]   bucket_count,
  input  logic [RW-1:0]               a,
  input  logic [RW-1:0]               b,
  output logic [RW-1:0]               res
);

  logic [NW-1:0]          n_ext;
  logic [NW-1:0]          n_eff;
  logic [KEY_BITS+NW-1:0] prod;
  logic [NW-1:0]          tag_full;

  // zero count acts as one bucket, large counts saturate
  always_comb begin
    n_ext = NW'(bucket_count);
    if (n_ext == '0) begin
      n_eff = NW'(1);
    end else if (n_ext > NW'(MAX_BUCKETS)) begin
      n_eff = NW'(MAX_BUCKETS);
    end else begin
      n_eff = n_ext;
    end
  end

  // key < 2^KEY_BITS, so the tag always stays below n_eff
  assign prod     = {{NW{1'b0}}, key} * {{KEY_BITS{1'b0}}, n_eff};
  assign tag_full = prod[KEY_BITS+NW-1:KEY_BITS];

  always_comb begin
    case (op)
      pbs_pkg::ALU_TAG: res = RW'(tag_full);
      pbs_pkg::ALU_ADD: res = a + b;
      default:          res = a + b;
    endcase
  end

endmodule

### rtl/pixel_bucket_sort.sv
// Stable bucket sort of one pixel segment.
// in_stream  : valid/ready words of pixel_value, sort_key (fraction of 2^KEY_BITS)
//              and segment_end. A word is taken only in ST_IDLE; the next is not taken
//              until its tag multiply and bucket-count read-modify-write are done.
// cfg_we/data: writes bucket_count (reset 16); write only while the block is idle.
// out_stream : valid/ready words of sorted_pixel and final_pixel, one per pixel of
//              the segment, final_pixel high on the last one.
// A segment closes on segment_end or on the MAX_PIXELS-th pixel. Closing runs a
// prefix pass over the counts, a stable scatter of the n pixels, then streams
// the results at up to one word per cycle while the receiver keeps ready high.
// The tag multiply and the count and position sums go through the one shared
// unit in pbs_alu; the count memory port bounds the load and scatter rates.
// After the last result is read out of the sorted store, a clearing pass
// zeroes the counts; in_stream.ready stays low meanwhile.
// Reset (rst_n, synchronous) starts with the same clearing pass.
// A stalled receiver holds the output register; the block still clears and
// takes the next segment behind it, but no new result overwrites a stalled word.
`include "assert_macros.svh"

module pixel_bucket_sort #(
  parameter int MAX_PIXELS  = 64,
  parameter int MAX_BUCKETS = 256,
  parameter int KEY_BITS    = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [pbs_pkg::CFG_W-1:0]   cfg_data,
  pbs_in_if.sink                      in_stream,
  pbs_out_if.source                   out_stream
);

  localparam int PIW   = $clog2(MAX_PIXELS);
  localparam int PCW   = $clog2(MAX_PIXELS + 1);
  localparam int TAG_W = $clog2(MAX_BUCKETS);
  localparam int BCW   = $clog2(MAX_BUCKETS + 1);
  localparam int IW    = (BCW > PCW) ? BCW : PCW;
  localparam int NW    = (pbs_pkg::CFG_W > BCW) ? pbs_pkg::CFG_W : BCW;
  localparam int RW    = (PCW > TAG_W) ? PCW : TAG_W;

  // configuration
  logic [pbs_pkg::CFG_W-1:0] bucket_count_r;

  // sequencer
  pbs_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [PCW-1:0]  ld_cnt_r, ld_cnt_nxt;
  logic [PCW-1:0]  run_r, run_nxt;
  logic            rv_r, rv_nxt;
  logic [TAG_W-1:0] wb_r, wb_nxt;
  logic            rd_v_r, rd_v_nxt;
  logic            rd_last_r, rd_last_nxt;

  // input capture
  logic [pbs_pkg::PIX_W-1:0] px_r;
  logic [KEY_BITS-1:0]       key_r;
  logic                      last_r;
  logic [TAG_W-1:0]          tag_r;

  // output register
  logic                      out_valid_r;
  logic [pbs_pkg::PIX_W-1:0] out_pix_r;
  logic                      out_final_r;

  // shared unit
  pbs_pkg::alu_op_t alu_op;
  logic [RW-1:0]    alu_a, alu_b, alu_res;
  logic [TAG_W-1:0] alu_tag;
  logic [PCW-1:0]   alu_sum;

  // memories
  logic                      pix_we, pix_re;
  logic [PIW-1:0]            pix_waddr, pix_raddr;
  logic [pbs_pkg::PIX_W-1:0] pix_rdata;
  logic [TAG_W-1:0]          tag_rdata;
  logic                      cnt_we, cnt_re;
  logic [TAG_W-1:0]          cnt_waddr, cnt_raddr;
  logic [PCW-1:0]            cnt_wdata, cnt_rdata;
  logic                      srt_we, srt_re;
  logic [PIW-1:0]            srt_waddr, srt_raddr;
  logic [pbs_pkg::PIX_W-1:0] srt_rdata;

  logic           in_acc;
  logic           load_out;
  logic           issue;
  logic [PCW-1:0] ld_inc;
  logic [IW-1:0]  idx_inc;

  assign in_acc    = in_stream.valid && in_stream.ready;
  assign ld_inc    = ld_cnt_r + PCW'(1);
  assign idx_inc   = idx_r + IW'(1);
  assign alu_tag   = alu_res[TAG_W-1:0];
  assign alu_sum   = alu_res[PCW-1:0];
  assign load_out  = rd_v_r && (!out_valid_r || out_stream.ready);

  assign in_stream.ready         = (state_r == pbs_pkg::ST_IDLE);
  assign out_stream.valid        = out_valid_r;
  assign out_stream.sorted_pixel = out_pix_r;
  assign out_stream.final_pixel  = out_final_r;

  pbs_alu #(
    .KEY_BITS    (KEY_BITS),
    .MAX_BUCKETS (MAX_BUCKETS),
    .NW          (NW),
    .RW          (RW)
  ) u_alu (
    .op           (alu_op),
    .key          (key_r),
    .bucket_count (bucket_count_r),
    .a            (alu_a),
    .b            (alu_b),
    .res          (alu_res)
  );

  pbs_ram #(.WIDTH(pbs_pkg::PIX_W), .DEPTH(MAX_PIXELS)) u_pixel_store (
    .clk (clk), .we (pix_we), .waddr (pix_waddr), .wdata (px_r),
    .re (pix_re), .raddr (pix_raddr), .rdata (pix_rdata)
  );

  pbs_ram #(.WIDTH(TAG_W), .DEPTH(MAX_PIXELS)) u_tag_store (
    .clk (clk), .we (pix_we), .waddr (pix_waddr), .wdata (alu_tag),
    .re (pix_re), .raddr (pix_raddr), .rdata (tag_rdata)
  );

  // bucket counts, reused in place as running positions after the prefix pass
  pbs_ram #(.WIDTH(PCW), .DEPTH(MAX_BUCKETS)) u_count_store (
    .clk (clk), .we (cnt_we), .waddr (cnt_waddr), .wdata (cnt_wdata),
    .re (cnt_re), .raddr (cnt_raddr), .rdata (cnt_rdata)
  );

  pbs_ram #(.WIDTH(pbs_pkg::PIX_W), .DEPTH(MAX_PIXELS)) u_sorted_store (
    .clk (clk), .we (srt_we), .waddr (srt_waddr), .wdata (pix_rdata),
    .re (srt_re), .raddr (srt_raddr), .rdata (srt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= pbs_pkg::CFG_RESET;
    end else if (cfg_we) begin
      bucket_count_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pbs_pkg::ST_CLEAR;
      idx_r     <= '0;
      ld_cnt_r  <= '0;
      rv_r      <= 1'b0;
      rd_v_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      ld_cnt_r  <= ld_cnt_nxt;
      rv_r      <= rv_nxt;
      rd_v_r    <= rd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r     <= run_nxt;
    wb_r      <= wb_nxt;
    rd_last_r <= rd_last_nxt;
    if (in_acc) begin
      px_r   <= in_stream.pixel_value;
      key_r  <= in_stream.sort_key;
      last_r <= in_stream.segment_end;
    end
    if (state_r == pbs_pkg::ST_TAG) begin
      tag_r <= alu_tag;
    end
  end

  // output register: take a new word when empty or when the held one leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pix_r   <= srt_rdata;
      out_final_r <= rd_last_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    ld_cnt_nxt  = ld_cnt_r;
    run_nxt     = run_r;
    rv_nxt      = 1'b0;
    wb_nxt      = wb_r;
    rd_v_nxt    = rd_v_r;
    rd_last_nxt = rd_last_r;
    issue       = 1'b0;

    alu_op = pbs_pkg::ALU_ADD;
    alu_a  = RW'(cnt_rdata);
    alu_b  = RW'(1);

    pix_we    = 1'b0;
    pix_waddr = ld_cnt_r[PIW-1:0];
    pix_re    = 1'b0;
    pix_raddr = idx_r[PIW-1:0];
    cnt_we    = 1'b0;
    cnt_waddr = tag_r;
    cnt_wdata = alu_sum;
    cnt_re    = 1'b0;
    cnt_raddr = alu_tag;
    srt_we    = 1'b0;
    srt_waddr = cnt_rdata[PIW-1:0];
    srt_re    = 1'b0;
    srt_raddr = idx_r[PIW-1:0];

    case (state_r)
      pbs_pkg::ST_CLEAR: begin
        // zero one bucket a cycle
        cnt_we    = 1'b1;
        cnt_waddr = idx_r[TAG_W-1:0];
        cnt_wdata = '0;
        idx_nxt   = idx_inc;
        if (idx_r == IW'(MAX_BUCKETS - 1)) begin
          idx_nxt    = '0;
          ld_cnt_nxt = '0;
          state_nxt  = pbs_pkg::ST_IDLE;
        end
      end

      pbs_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = pbs_pkg::ST_TAG;
        end
      end

      pbs_pkg::ST_TAG: begin
        // tag the pixel, store both and fetch its bucket count
        alu_op    = pbs_pkg::ALU_TAG;
        pix_we    = 1'b1;
        cnt_re    = 1'b1;
        cnt_raddr = alu_tag;
        state_nxt = pbs_pkg::ST_CNT;
      end

      pbs_pkg::ST_CNT: begin
        cnt_we     = 1'b1;
        cnt_waddr  = tag_r;
        cnt_wdata  = alu_sum;
        ld_cnt_nxt = ld_inc;
        if (last_r || (ld_inc == PCW'(MAX_PIXELS))) begin
          idx_nxt   = '0;
          run_nxt   = '0;
          state_nxt = pbs_pkg::ST_PFX;
        end else begin
          state_nxt = pbs_pkg::ST_IDLE;
        end
      end

      pbs_pkg::ST_PFX: begin
        // read bucket idx, write the start position of the bucket read last cycle
        issue  = (idx_r != IW'(MAX_BUCKETS));
        cnt_re = issue;
        cnt_raddr = idx_r[TAG_W-1:0];
        if (issue) begin
          idx_nxt = idx_inc;
        end
        rv_nxt = issue;
        wb_nxt = idx_r[TAG_W-1:0];
        alu_a  = RW'(run_r);
        alu_b  = RW'(cnt_rdata);
        if (rv_r) begin
          cnt_we    = 1'b1;
          cnt_waddr = wb_r;
          cnt_wdata = run_r;
          run_nxt   = alu_sum;
          if (wb_r == TAG_W'(MAX_BUCKETS - 1)) begin
            idx_nxt   = '0;
            state_nxt = pbs_pkg::ST_SC_RD;
          end
        end
      end

      pbs_pkg::ST_SC_RD: begin
        pix_re    = 1'b1;
        state_nxt = pbs_pkg::ST_SC_POS;
      end

      pbs_pkg::ST_SC_POS: begin
        cnt_re    = 1'b1;
        cnt_raddr = tag_rdata;
        state_nxt = pbs_pkg::ST_SC_WR;
      end

      pbs_pkg::ST_SC_WR: begin
        // place the pixel and advance its bucket position
        srt_we    = 1'b1;
        srt_waddr = cnt_rdata[PIW-1:0];
        cnt_we    = 1'b1;
        cnt_waddr = tag_rdata;
        cnt_wdata = alu_sum;
        if (idx_inc == IW'(ld_cnt_r)) begin
          idx_nxt   = '0;
          state_nxt = pbs_pkg::ST_EMIT;
        end else begin
          idx_nxt   = idx_inc;
          pix_re    = 1'b1;
          pix_raddr = idx_inc[PIW-1:0];
          state_nxt = pbs_pkg::ST_SC_POS;
        end
      end

      pbs_pkg::ST_EMIT: begin
        // read ahead one word, refill as the output register drains
        issue  = (idx_r != IW'(ld_cnt_r)) && (!rd_v_r || load_out);
        srt_re = issue;
        if (issue) begin
          idx_nxt     = idx_inc;
          rd_v_nxt    = 1'b1;
          rd_last_nxt = (idx_inc == IW'(ld_cnt_r));
        end else if (load_out) begin
          rd_v_nxt = 1'b0;
        end
        if ((idx_r == IW'(ld_cnt_r)) && !rd_v_r) begin
          idx_nxt   = '0;
          state_nxt = pbs_pkg::ST_CLEAR;
        end
      end

      default: begin
        state_nxt = pbs_pkg::ST_CLEAR;
        idx_nxt   = '0;
      end
    endcase
  end

  // counts summed over all buckets must equal the pixels loaded
  `PBS_ASSERT_NEXT(a_prefix_total, clk, rst_n, (state_r == pbs_pkg::ST_PFX) && (state_nxt == pbs_pkg::ST_SC_RD), run_r == ld_cnt_r, "prefix total differs from loaded count")
  // every scatter position lands inside the segment
  `PBS_ASSERT_NOW(a_scatter_pos, clk, rst_n, state_r == pbs_pkg::ST_SC_WR, cnt_rdata < ld_cnt_r, "scatter position out of range")
  // the load count never passes the store depth
  `PBS_ASSERT_NOW(a_load_bound, clk, rst_n, state_r == pbs_pkg::ST_CNT, ld_cnt_r < PCW'(MAX_PIXELS), "pixel store overrun")

endmodule
